/* rtl/zcrm_pkg.sv */
// ----------------------------------------------------------------------------
// zcrm_pkg: shared definitions for the zero-crossing RMS meter
// Widths, register indexes, state encodings and the structs exchanged
// between the sequencer, the channel store and the divide/root unit.
// ----------------------------------------------------------------------------
package zcrm_pkg;

   localparam int CHANNELS = 16;
   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int CHAN_FIELD_W = 4;
   localparam int SAMPLE_W     = 16;
   localparam int RMS_W        = 16;
   localparam int SUM_W        = 48;
   localparam int COUNT_W      = 16;
   localparam int SQUARE_W     = 31;
   localparam int CFG_W        = 16;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   localparam logic [CFG_W-1:0] MIN_CYCLE_RESET = 16'd250;
   localparam logic [CFG_W-1:0] MIN_HALF_RESET  = 16'd50;

   typedef enum logic [0:0] {
      REG_MIN_CYCLE = 1'b0,
      REG_MIN_HALF  = 1'b1
   } reg_index_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQUARE = 6'b000010,
      ST_ACCUM  = 6'b000100,
      ST_WAIT   = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_SKIP   = 6'b100000
   } seq_state_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_DIV  = 3'b010,
      PH_SQRT = 3'b100
   } ds_phase_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
      logic               seen;
      logic [RMS_W-1:0]   held;
   } chan_state_type;

   typedef struct packed {
      logic               start;
      logic [SUM_W-1:0]   dividend;
      logic [COUNT_W-1:0] divisor;
   } ds_ctrl_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [RMS_W-1:0] root;
   } ds_stat_type;

endpackage

/* rtl/zcrm_chan_store.sv */
// ----------------------------------------------------------------------------
// zcrm_chan_store: per-channel accumulator state
// One entry per channel holding the sum of squares, the sample count, the
// polarity flag and the held RMS. All entries clear on reset.
// ----------------------------------------------------------------------------
module zcrm_chan_store
   import zcrm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [CH_W-1:0] rd_index,
   output chan_state_type  rd_state,
   input  logic            wr_en,
   input  logic [CH_W-1:0] wr_index,
   input  chan_state_type  wr_state
);

   chan_state_type entry_ff [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr_en) begin
         entry_ff[wr_index] <= wr_state;
      end
   end

   assign rd_state = entry_ff[rd_index];

endmodule

/* rtl/zcrm_divsqrt.sv */
// ----------------------------------------------------------------------------
// zcrm_divsqrt: iterative divide and square root
// Computes floor(sqrt(floor(dividend / divisor))) with one shared
// subtract-and-compare unit: 48 restoring divide steps, then 24 root steps.
// ----------------------------------------------------------------------------
module zcrm_divsqrt
   import zcrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  ds_ctrl_type ctrl,
   output ds_stat_type stat
);

   localparam int REM_W  = 26;
   localparam int ROOT_W = SUM_W / 2;
   localparam int ITER_W = $clog2(SUM_W);

   ds_phase_type      phase_ff, phase_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  work_ff, work_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [COUNT_W-1:0] divisor_ff, divisor_in;
   logic              done_ff, done_in;

   // Shared unit: operands chosen by phase, one subtractor, borrow is compare.
   logic [REM_W-1:0] op_a, op_b;
   logic [REM_W:0]   diff;
   logic             ge;

   always_comb begin
      if (phase_ff == PH_SQRT) begin
         op_a = {rem_ff[REM_W-3:0], work_ff[SUM_W-1 -: 2]};
         op_b = {root_ff, 2'b01};
      end else begin
         op_a = {{(REM_W-COUNT_W-1){1'b0}}, rem_ff[COUNT_W-1:0], work_ff[SUM_W-1]};
         op_b = {{(REM_W-COUNT_W){1'b0}}, divisor_ff};
      end
      diff = {1'b0, op_a} - {1'b0, op_b};
      ge   = ~diff[REM_W];
   end

   always_comb begin
      phase_in   = phase_ff;
      iter_in    = iter_ff;
      rem_in     = rem_ff;
      work_in    = work_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (ctrl.start) begin
               phase_in   = PH_DIV;
               iter_in    = ITER_W'(SUM_W - 1);
               rem_in     = '0;
               work_in    = ctrl.dividend;
               divisor_in = ctrl.divisor;
            end
         end
         PH_DIV: begin
            rem_in  = ge ? diff[REM_W-1:0] : op_a;
            work_in = {work_ff[SUM_W-2:0], ge};
            if (iter_ff == '0) begin
               phase_in = PH_SQRT;
               iter_in  = ITER_W'(ROOT_W - 1);
            end else begin
               iter_in = iter_ff - 1'b1;
            end
            // The root pass starts from an empty remainder and root.
            if (iter_ff == '0) begin
               rem_in  = '0;
               root_in = '0;
            end
         end
         PH_SQRT: begin
            rem_in  = ge ? diff[REM_W-1:0] : op_a;
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            root_in = {root_ff[ROOT_W-2:0], ge};
            if (iter_ff == '0) begin
               phase_in = PH_IDLE;
               done_in  = 1'b1;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      iter_ff    <= iter_in;
      rem_ff     <= rem_in;
      work_ff    <= work_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
   end

   assign stat.busy = (phase_ff != PH_IDLE);
   assign stat.done = done_ff;
   assign stat.root = (|root_ff[ROOT_W-1:RMS_W]) ? {RMS_W{1'b1}} : root_ff[RMS_W-1:0];

endmodule

/* rtl/zero_cross_rms_meter.sv */
// ----------------------------------------------------------------------------
// zero_cross_rms_meter: per-channel RMS meter gated by zero crossings
// Accumulates squared samples per channel and, on a qualifying positive
// crossing, stores the integer RMS of the completed cycle.
// ----------------------------------------------------------------------------
// One request is processed at a time. A request that does not close a cycle
// presents its result after square, accumulate and write back, and the next
// request can be taken once the write back is done. One that closes a cycle
// also passes through the shared divide and root unit, which performs 48
// divide steps and 24 root steps, one per cycle, and hands the root back
// through a registered done flag. The result sits in an output register, so
// a new request is taken while the previous result still waits, but the
// result of that new request is held back until the output register is free.
module zero_cross_rms_meter
   import zcrm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: [3:0] channel, [19:4] sample, upper bits zero
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: [15:0] rms_value, [16] rms_updated, upper bits zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [0:0]            csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int CH_EXT_W = 7;

   seq_state_type      state_ff, state_in;
   logic [CFG_W-1:0]   min_cycle_ff, min_half_ff;
   logic [CH_W-1:0]    index_ff, index_in;
   logic               positive_ff, positive_in;
   logic               negative_ff, negative_in;
   logic [SAMPLE_W:0]  mag_ff, mag_in;
   logic [SQUARE_W-1:0] square_ff;
   chan_state_type     pend_ff, pend_in;
   logic               updated_ff, updated_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0]   rsp_rms_ff, rsp_rms_in;
   logic               rsp_upd_ff, rsp_upd_in;

   logic [CHAN_FIELD_W-1:0] req_channel;
   logic [SAMPLE_W-1:0]     req_sample;
   logic [CH_EXT_W-1:0]     ch_ext;
   logic                    ch_ok;
   logic [2*SAMPLE_W+1:0]   product;
   logic [SUM_W:0]          sum_add;
   logic [SUM_W-1:0]        sum_new;
   logic [COUNT_W-1:0]      count_new;
   logic                    close_cycle, rearm;
   logic                    out_free, out_load, store_we;

   chan_state_type cur_state;
   ds_ctrl_type    ds_ctrl;
   ds_stat_type    ds_stat;

   assign req_channel = req_tdata[CHAN_FIELD_W-1:0];
   assign req_sample  = req_tdata[CHAN_FIELD_W +: SAMPLE_W];
   assign ch_ext      = {{(CH_EXT_W-CHAN_FIELD_W){1'b0}}, req_channel};
   assign ch_ok       = ch_ext < CH_EXT_W'(CHANNELS);

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_cycle_ff <= MIN_CYCLE_RESET;
         min_half_ff  <= MIN_HALF_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_MIN_CYCLE: min_cycle_ff <= csr_wdata;
            REG_MIN_HALF:  min_half_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   zcrm_chan_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_index (index_ff),
      .rd_state (cur_state),
      .wr_en    (store_we),
      .wr_index (index_ff),
      .wr_state (pend_ff)
   );

   zcrm_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .ctrl  (ds_ctrl),
      .stat  (ds_stat)
   );

   assign product   = mag_ff * mag_ff;
   assign sum_add   = {1'b0, cur_state.sum} + {{(SUM_W-SQUARE_W+1){1'b0}}, square_ff};
   assign sum_new   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign count_new = (&cur_state.count) ? cur_state.count : cur_state.count + 1'b1;
   assign close_cycle = positive_ff & ~cur_state.seen & (count_new > min_cycle_ff);
   assign rearm       = negative_ff & cur_state.seen & (count_new > min_half_ff);

   assign ds_ctrl.start    = (state_ff == ST_ACCUM) & close_cycle;
   assign ds_ctrl.dividend = sum_new;
   assign ds_ctrl.divisor  = count_new;

   assign out_load = ((state_ff == ST_FINISH) || (state_ff == ST_SKIP)) && out_free;
   assign store_we = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      state_in     = state_ff;
      index_in     = index_ff;
      positive_in  = positive_ff;
      negative_in  = negative_ff;
      mag_in       = mag_ff;
      pend_in      = pend_ff;
      updated_in   = updated_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_rms_in   = rsp_rms_ff;
      rsp_upd_in   = rsp_upd_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               index_in    = ch_ext[CH_W-1:0];
               negative_in = req_sample[SAMPLE_W-1];
               positive_in = ~req_sample[SAMPLE_W-1] & (|req_sample);
               mag_in      = req_sample[SAMPLE_W-1]
                             ? (17'h10000 - {1'b0, req_sample}) : {1'b0, req_sample};
               updated_in  = 1'b0;
               state_in    = ch_ok ? ST_SQUARE : ST_SKIP;
            end
         end
         ST_SQUARE: begin
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            if (close_cycle) begin
               pend_in.sum   = '0;
               pend_in.count = '0;
               pend_in.seen  = 1'b1;
               pend_in.held  = cur_state.held;
               state_in      = ST_WAIT;
            end else begin
               pend_in.sum   = sum_new;
               pend_in.count = count_new;
               pend_in.seen  = cur_state.seen & ~rearm;
               pend_in.held  = cur_state.held;
               state_in      = ST_FINISH;
            end
         end
         ST_WAIT: begin
            if (ds_stat.done) begin
               pend_in.held = ds_stat.root;
               updated_in   = 1'b1;
               state_in     = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rms_in   = pend_ff.held;
               rsp_upd_in   = updated_ff;
               state_in     = ST_IDLE;
            end
         end
         ST_SKIP: begin
            // A channel beyond the store leaves all state alone and reports zero.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rms_in   = '0;
               rsp_upd_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      index_ff    <= index_in;
      positive_ff <= positive_in;
      negative_ff <= negative_in;
      mag_ff      <= mag_in;
      square_ff   <= product[SQUARE_W-1:0];
      pend_ff     <= pend_in;
      updated_ff  <= updated_in;
      rsp_rms_ff  <= rsp_rms_in;
      rsp_upd_ff  <= rsp_upd_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RMS_W-1){1'b0}}, rsp_upd_ff, rsp_rms_ff};

   // The shared unit only runs while the sequencer waits for it.
   a_unit_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      ds_stat.busy |-> (state_ff == ST_WAIT))
      else $error("divide/root unit busy outside the wait state");

   // A closed cycle always writes back an emptied accumulator with the flag set.
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (store_we && updated_ff) |-> (pend_ff.count == '0 && pend_ff.sum == '0 && pend_ff.seen))
      else $error("closed cycle does not clear the accumulator");

   // A loaded result is followed by a new request window.
   a_load_then_idle: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (state_ff == ST_IDLE) && rsp_tvalid)
      else $error("result load did not return the sequencer to idle");

   // No request is taken while the divide/root unit is working.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ds_stat.busy |-> !req_tready)
      else $error("request accepted while the unit is busy");

endmodule

/* test/zero_cross_rms_meter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zero_cross_rms_meter_tb: self-checking bench for the zero-crossing RMS meter
// Sends directed and waveform-shaped random samples over the request stream
// and predicts every reading from a private model of the per-channel sums,
// counts, polarity flags and held RMS values. Readings are checked in order
// against that prediction under random pacing and a long receiver hold-off.
// ----------------------------------------------------------------------------
module zero_cross_rms_meter_tb
   import zcrm_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 100;
   localparam logic [63:0] SUM_LIMIT   = 64'h0000_FFFF_FFFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;

   typedef struct packed {
      logic [RMS_W-1:0] rms;
      logic             updated;
   } reading_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [0:0]            csr_addr;
   logic [CFG_W-1:0]      csr_wdata;

   // Private copy of the meter state and thresholds.
   logic [SUM_W-1:0]   chan_sum   [CHANNELS];
   logic [COUNT_W-1:0] chan_count [CHANNELS];
   logic               chan_seen  [CHANNELS];
   logic [RMS_W-1:0]   chan_held  [CHANNELS];
   logic [CFG_W-1:0]   min_cycle;
   logic [CFG_W-1:0]   min_half;

   reading_type pending_readings[$];
   int       failures;
   int       quiet_cycles;
   bit       pace_enable;
   bit       hold_pending;
   int       wave_pos [CHANNELS];
   int       half_len [CHANNELS];

   zero_cross_rms_meter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor square root by building the root one bit at a time from the top.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 24; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x)
            root = trial;
      end
      return root;
   endfunction

   function automatic reading_type predict_reading(input logic [3:0] ch,
                                                   input logic [SAMPLE_W-1:0] smp);
      logic        negative;
      logic        positive;
      logic [16:0] mag;
      logic [63:0] square;
      logic [63:0] mean;
      logic [63:0] root;
      reading_type res;
      res = '0;
      if (ch >= CHANNELS)
         return res;
      negative = smp[SAMPLE_W-1];
      positive = !negative && (smp != 0);
      mag      = negative ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
      square   = {47'd0, mag} * {47'd0, mag};
      if (chan_count[ch] != COUNT_LIMIT)
         chan_count[ch] = chan_count[ch] + 1'b1;
      if ({16'd0, chan_sum[ch]} > SUM_LIMIT - square)
         chan_sum[ch] = SUM_LIMIT[SUM_W-1:0];
      else
         chan_sum[ch] = chan_sum[ch] + square[SUM_W-1:0];
      if (positive && !chan_seen[ch] && chan_count[ch] > min_cycle) begin
         mean = {16'd0, chan_sum[ch]} / {48'd0, chan_count[ch]};
         root = floor_sqrt(mean);
         chan_held[ch]  = (root > 64'hFFFF) ? 16'hFFFF : root[RMS_W-1:0];
         chan_sum[ch]   = '0;
         chan_count[ch] = '0;
         chan_seen[ch]  = 1'b1;
         res.updated    = 1'b1;
      end else if (negative && chan_seen[ch] && chan_count[ch] > min_half) begin
         chan_seen[ch] = 1'b0;
      end
      res.rms = chan_held[ch];
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      failures++;
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_sample(input logic [3:0] ch, input logic [SAMPLE_W-1:0] smp);
      int gap;
      gap = pace_enable ? $urandom_range(7, 0) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, smp, ch};
      do
         @(posedge clock);
      while (!req_tready);
      pending_readings.push_back(predict_reading(ch, smp));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [CFG_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_MIN_CYCLE: min_cycle = value;
         REG_MIN_HALF:  min_half  = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_thresholds(input logic [CFG_W-1:0] cycle_min,
                                 input logic [CFG_W-1:0] half_min);
      wait_drained();
      write_register(REG_MIN_CYCLE, cycle_min);
      write_register(REG_MIN_HALF, half_min);
   endtask

   // Square-ish waveforms per channel with random amplitude, plus some noise
   // and zeros that break the sequences.
   task automatic drive_waveform(input int n, input int ch_lo, input int ch_hi,
                                 input int len_lo, input int len_hi);
      int ch;
      int pick;
      logic [SAMPLE_W-1:0] smp;
      for (int c = 0; c < CHANNELS; c++) begin
         wave_pos[c] = 0;
         half_len[c] = $urandom_range(len_hi, len_lo);
      end
      for (int i = 0; i < n; i++) begin
         ch   = $urandom_range(ch_hi, ch_lo);
         pick = $urandom_range(99, 0);
         if (pick < 8)
            smp = 16'($urandom);
         else if (pick < 12)
            smp = '0;
         else if (wave_pos[ch] < half_len[ch])
            smp = (pick < 16) ? 16'h7FFF : 16'($urandom_range(32767, 1));
         else
            smp = (pick < 16) ? 16'h8000 : 16'(0 - $urandom_range(32768, 1));
         wave_pos[ch]++;
         if (wave_pos[ch] >= 2 * half_len[ch]) begin
            wave_pos[ch] = 0;
            half_len[ch] = $urandom_range(len_hi, len_lo);
         end
         send_sample(ch[3:0], smp);
      end
   endtask

   task automatic test_directed();
      set_thresholds(16'd2, 16'd1);
      send_sample(4'd0, 16'h7FFF);
      send_sample(4'd0, 16'h7FFF);
      send_sample(4'd0, 16'h7FFF);
      send_sample(4'd0, 16'h8000);
      send_sample(4'd0, 16'h8000);
      send_sample(4'd0, 16'h0000);
      send_sample(4'd0, 16'h0001);
      send_sample(4'd15, 16'hFFFF);
      send_sample(4'd15, 16'h0000);
      send_sample(4'd15, 16'h0001);
      send_sample(4'd15, 16'h0001);
      send_sample(4'd15, 16'hFFFF);
      send_sample(4'd15, 16'hFFFF);
      send_sample(4'd15, 16'h7FFF);
      set_thresholds(16'd0, 16'd0);
      send_sample(4'd5, 16'h0001);
      send_sample(4'd5, 16'hFFFF);
      send_sample(4'd5, 16'h0000);
      send_sample(4'd5, 16'h7FFF);
      send_sample(4'd10, 16'h0000);
      send_sample(4'd10, 16'h0000);
      send_sample(4'd10, 16'h5A5A);
   endtask

   task automatic test_random_waves();
      set_thresholds(16'd20, 16'd8);
      drive_waveform(600, 0, CHANNELS - 1, 10, 30);
      set_thresholds(16'd0, 16'd0);
      drive_waveform(300, 0, CHANNELS - 1, 1, 6);
      // With both thresholds at the top no cycle can ever close.
      set_thresholds(16'hFFFF, 16'hFFFF);
      drive_waveform(100, 0, CHANNELS - 1, 1, 20);
      set_thresholds(MIN_CYCLE_RESET, MIN_HALF_RESET);
      drive_waveform(500, 0, 1, 60, 200);
   endtask

   task automatic test_backpressure();
      set_thresholds(16'd5, 16'd3);
      hold_pending = 1'b1;
      drive_waveform(350, 0, CHANNELS - 1, 3, 8);
   endtask

   // Receiver: random stalls per reading, and one long hold-off on request.
   initial begin : receiver
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            gap = pace_enable ? $urandom_range(7, 0) : 0;
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do
            @(posedge clock);
         while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : reading_check
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("unexpected reading %h", rsp_tdata));
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[RMS_W-1:0] !== want.rms)
               report_mismatch($sformatf("rms_value %0d, expected %0d",
                                         rsp_tdata[RMS_W-1:0], want.rms));
            if (rsp_tdata[RMS_W] !== want.updated)
               report_mismatch($sformatf("rms_updated %b, expected %b",
                                         rsp_tdata[RMS_W], want.updated));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("zero_cross_rms_meter_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : main
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      failures     = 0;
      pace_enable  = 1'b1;
      hold_pending = 1'b0;
      min_cycle    = MIN_CYCLE_RESET;
      min_half     = MIN_HALF_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         chan_sum[c]   = '0;
         chan_count[c] = '0;
         chan_seen[c]  = 1'b0;
         chan_held[c]  = '0;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_random_waves();
      test_backpressure();

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (failures == 0 && pending_readings.size() == 0)
         $display("zero_cross_rms_meter_tb OK");
      else
         $display("zero_cross_rms_meter_tb NOT OK");
      $finish;
   end

endmodule
